// ----- rtl/nht_pkg.sv -----
package nht_pkg;

  // one table entry as it travels along the row of cells
  typedef struct packed {
    logic [63:0]        key_lo;
    logic [63:0]        key_hi;
    logic [6:0]         cnt;
    logic [5:0]         badges;
    logic [2:0]         mark;
    logic signed [15:0] stamp;
  } entry_t;

  // one result item
  typedef struct packed {
    logic               hit;
    logic               inserted;
    logic [4:0]         slot;
    logic               evicted;
    logic [63:0]        old_name_lo;
    logic [63:0]        old_name_hi;
    logic [6:0]         old_count;
    logic [5:0]         old_badges;
    logic [2:0]         old_mark;
    logic signed [15:0] old_stamp;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PICK,
    ST_INS,
    ST_DONE
  } state_e;

  localparam logic [5:0] BADGE_FULL = 6'h3F;
  localparam logic [6:0] CNT_CAP    = 7'h3F;
  localparam logic [6:0] CNT_MAX    = 7'h7F;
  localparam logic [2:0] MARK_DONE  = 3'd7;
  localparam int         NUM_BADGES = 6;

  // clear every byte after the first zero byte
  function automatic logic [127:0] canon_name(input logic [127:0] n);
    logic [127:0] r;
    logic         ended;
    r     = n;
    ended = 1'b0;
    for (int b = 0; b < 16; b++) begin
      if (ended) begin
        r[b*8 +: 8] = 8'h00;
      end else if (n[b*8 +: 8] == 8'h00) begin
        ended = 1'b1;
      end
    end
    return r;
  endfunction

  // value mod 6 from its parity and a base-4 digit sum mod 3
  function automatic logic [2:0] rem6(input logic [15:0] x);
    logic [4:0] s;
    logic [2:0] t;
    logic [2:0] u;
    logic [1:0] r3;
    logic [2:0] r;
    s = '0;
    for (int d = 0; d < 8; d++) s = s + 5'(x[2*d +: 2]);
    t  = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
    u  = 3'(t[1:0]) + 3'(t[2]);
    r3 = (u >= 3'd3) ? 2'(u - 3'd3) : u[1:0];
    case ({r3, x[0]})
      3'b00_0: r = 3'd0;
      3'b01_0: r = 3'd4;
      3'b10_0: r = 3'd2;
      3'b00_1: r = 3'd3;
      3'b01_1: r = 3'd1;
      3'b10_1: r = 3'd5;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  // new count values 14, 24, 34 and so on earn a badge
  function automatic logic is_milestone(input logic [6:0] c);
    logic m;
    m = 1'b0;
    for (int j = 0; j < 12; j++) begin
      if (c == 7'(14 + 10 * j)) m = 1'b1;
    end
    return m;
  endfunction

  // entry update on a name match
  function automatic entry_t hit_update(input entry_t e, input logic signed [15:0] now,
                                        input logic [2:0] b0);
    entry_t     r;
    logic [6:0] c;
    logic [2:0] b;
    logic       found;
    r       = e;
    r.stamp = now;
    if (e.badges == BADGE_FULL) begin
      if (e.cnt < CNT_CAP) begin
        r.cnt = e.cnt + 7'd1;
      end else begin
        r.cnt  = CNT_CAP;
        r.mark = MARK_DONE;
      end
    end else begin
      c = (e.cnt == CNT_MAX) ? CNT_MAX : e.cnt + 7'd1;
      if (is_milestone(c)) begin
        b     = b0;
        found = 1'b0;
        for (int t = 0; t < NUM_BADGES; t++) begin
          if (!found) begin
            if (!e.badges[b]) found = 1'b1;
            else b = (b == 3'(NUM_BADGES - 1)) ? 3'd0 : b + 3'd1;
          end
        end
        r.mark   = b;
        r.badges = e.badges | (6'd1 << b);
      end
      r.cnt = c;
    end
    return r;
  endfunction

endpackage

// ----- rtl/nht_in_if.sv -----
interface nht_in_if;
  logic               valid;
  logic               ready;
  logic [63:0]        name_lo;
  logic [63:0]        name_hi;
  logic signed [15:0] now;
  logic [15:0]        rand_pick;
  logic [15:0]        rand_bit;

  modport source (output valid, name_lo, name_hi, now, rand_pick, rand_bit, input ready);
  modport sink   (input valid, name_lo, name_hi, now, rand_pick, rand_bit, output ready);
endinterface

// ----- rtl/nht_out_if.sv -----
interface nht_out_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic               inserted;
  logic [4:0]         slot;
  logic               evicted;
  logic [63:0]        old_name_lo;
  logic [63:0]        old_name_hi;
  logic [6:0]         old_count;
  logic [5:0]         old_badges;
  logic [2:0]         old_mark;
  logic signed [15:0] old_stamp;

  modport source (output valid, hit, inserted, slot, evicted, old_name_lo, old_name_hi,
                  old_count, old_badges, old_mark, old_stamp, input ready);
  modport sink   (input valid, hit, inserted, slot, evicted, old_name_lo, old_name_hi,
                  old_count, old_badges, old_mark, old_stamp, output ready);
endinterface

// ----- rtl/named_history_table_lfu_replace.sv -----
// Named history table with least-used replacement. The entries sit in a ring
// of ENTRIES cells that rotates one place per cycle, while the block scans or
// inserts, past a single update unit at the head. An accepted item has
// rand_bit mod 6 taken at once, then makes one full rotation for the
// match/update and least-used scan. A hit, or a table that is full and all
// marked 7, ends there and the result is loaded from ST_DONE once the output
// register is free. A miss into a table with empty slots first takes rand_pick
// mod empty count in a serial divider, and every insert takes one more
// rotation of the ring, into an empty slot or as an eviction. The input is
// ready again the cycle the result is loaded; a result that waits on the
// output holds the block. The ring comes out of reset cleared, so no clearing
// pass is needed.
module named_history_table_lfu_replace #(
  parameter int ENTRIES = 21
) (
  input  logic clk_i,
  input  logic rst_ni,
  nht_in_if.sink    in_i,
  nht_out_if.source out_o
);
  import nht_pkg::*;

  localparam int IW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW  = $clog2(ENTRIES + 1);
  localparam int DW  = (CW < 3) ? 3 : CW;
  localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

  state_e  state_q, state_d;
  entry_t  cell_q [ENTRIES];
  entry_t  head, tail_d;
  logic    shift;

  logic [63:0]        name_lo_q, name_hi_q;
  logic signed [15:0] now_q;
  logic [15:0]        rpick_q;
  logic [2:0]         bsel_q;
  logic [IW-1:0]      idx_q, cand_q;
  logic               hit_q;
  logic [CW-1:0]      n_empty_q, n_empty_d, n_seven_q, n_seven_d, ecnt_q, target_q;
  logic [7:0]         min_cnt_q, min_cnt_d;
  logic signed [15:0] min_ts_q;
  logic               min_ts_vld_q;
  result_t            res_q;
  result_t            out_q;
  logic               out_vld_q;

  logic          div_start, div_done;
  logic [15:0]   div_num;
  logic [DW-1:0] div_den, div_rem;

  logic match, head_empty, cnt_lt, cnt_eq, ts_lt, sel, accept, load_out;

  // ring of cells, head at cell 0, processed entry re-enters at the tail
  for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
    entry_t nb;
    if (k == ENTRIES - 1) begin : g_tail
      assign nb = tail_d;
    end else begin : g_mid
      assign nb = cell_q[k+1];
    end
    nht_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .entry_i (nb),
      .entry_o (cell_q[k])
    );
  end

  assign head       = cell_q[0];
  assign head_empty = (head.key_lo[7:0] == 8'h00);
  assign match      = (head.key_lo == name_lo_q) && (head.key_hi == name_hi_q);
  assign shift      = (state_q == ST_SCAN) || (state_q == ST_INS);
  assign accept     = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);

  // least-used compare on the head entry
  assign cnt_lt    = {1'b0, head.cnt} < min_cnt_q;
  assign min_cnt_d = cnt_lt ? {1'b0, head.cnt} : min_cnt_q;
  assign cnt_eq    = ({1'b0, head.cnt} == min_cnt_d);
  assign ts_lt     = !min_ts_vld_q || (head.stamp < min_ts_q);

  // empty and mark-7 counts including the head
  always_comb begin
    n_empty_d = n_empty_q;
    n_seven_d = n_seven_q;
    if (head_empty) n_empty_d = n_empty_q + CW'(1);
    else if (head.mark == MARK_DONE) n_seven_d = n_seven_q + CW'(1);
  end

  // insert position in the second rotation
  assign sel = (n_empty_q != '0) ? (head_empty && (ecnt_q == target_q)) : (idx_q == cand_q);

  // divider for rand_pick mod empty count, started on the last scan cycle
  assign div_start = (state_q == ST_SCAN) && (idx_q == LAST) && !hit_q && !match &&
                     (n_seven_d != CW'(ENTRIES)) && (n_empty_d != '0);
  assign div_num   = rpick_q;
  assign div_den   = DW'(n_empty_d);

  nht_div #(.DW(DW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  // next state and the entry written back at the tail
  always_comb begin
    state_d  = state_q;
    tail_d   = head;
    load_out = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (match) tail_d = hit_update(head, now_q, bsel_q);
        if (idx_q == LAST) begin
          if (hit_q || match || n_seven_d == CW'(ENTRIES)) state_d = ST_DONE;
          else if (n_empty_d == '0) state_d = ST_INS;
          else state_d = ST_PICK;
        end
      end
      ST_PICK: begin
        if (div_done) state_d = ST_INS;
      end
      ST_INS: begin
        if (sel) begin
          tail_d.key_lo = name_lo_q;
          tail_d.key_hi = name_hi_q;
          tail_d.mark   = 3'd0;
          tail_d.cnt    = 7'd1;
          tail_d.badges = 6'd1;
          tail_d.stamp  = now_q;
        end
        if (idx_q == LAST) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_vld_q || out_o.ready) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) out_vld_q <= 1'b1;
      else if (out_o.ready) out_vld_q <= 1'b0;
    end
  end

  // item context, scan accumulators and result
  always_ff @(posedge clk_i) begin
    if (accept) begin
      {name_hi_q, name_lo_q} <= canon_name({in_i.name_hi, in_i.name_lo});
      now_q        <= in_i.now;
      rpick_q      <= in_i.rand_pick;
      bsel_q       <= rem6(in_i.rand_bit);
      res_q        <= '0;
      hit_q        <= 1'b0;
      idx_q        <= '0;
      cand_q       <= '0;
      n_empty_q    <= '0;
      n_seven_q    <= '0;
      ecnt_q       <= '0;
      min_cnt_q    <= 8'h80;
      min_ts_vld_q <= 1'b0;
      min_ts_q     <= '0;
    end
    if (state_q == ST_PICK && div_done) target_q <= CW'(div_rem);
    if (state_q == ST_SCAN) begin
      idx_q     <= (idx_q == LAST) ? '0 : idx_q + IW'(1);
      n_empty_q <= n_empty_d;
      n_seven_q <= n_seven_d;
      min_cnt_q <= min_cnt_d;
      if (cnt_lt || (cnt_eq && ts_lt)) cand_q <= idx_q;
      if (cnt_eq && ts_lt) begin
        min_ts_q     <= head.stamp;
        min_ts_vld_q <= 1'b1;
      end
      if (match) begin
        hit_q     <= 1'b1;
        res_q.hit <= 1'b1;
      end
    end
    if (state_q == ST_INS) begin
      idx_q <= (idx_q == LAST) ? '0 : idx_q + IW'(1);
      if (head_empty) ecnt_q <= ecnt_q + CW'(1);
      if (sel) begin
        res_q.inserted <= 1'b1;
        res_q.slot     <= 5'(idx_q);
        if (n_empty_q == '0) begin
          res_q.evicted     <= 1'b1;
          res_q.old_name_lo <= head.key_lo;
          res_q.old_name_hi <= head.key_hi;
          res_q.old_count   <= head.cnt;
          res_q.old_badges  <= head.badges;
          res_q.old_mark    <= head.mark;
          res_q.old_stamp   <= head.stamp;
        end
      end
    end
    if (load_out) out_q <= res_q;
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.hit         = out_q.hit;
  assign out_o.inserted    = out_q.inserted;
  assign out_o.slot        = out_q.slot;
  assign out_o.evicted     = out_q.evicted;
  assign out_o.old_name_lo = out_q.old_name_lo;
  assign out_o.old_name_hi = out_q.old_name_hi;
  assign out_o.old_count   = out_q.old_count;
  assign out_o.old_badges  = out_q.old_badges;
  assign out_o.old_mark    = out_q.old_mark;
  assign out_o.old_stamp   = out_q.old_stamp;

`ifndef ASSERT_OFF
  a_hit_no_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.hit |-> !out_q.inserted)
    else $error("hit result also reports an insert");
  a_evict_inserts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.evicted |-> out_q.inserted)
    else $error("eviction without insert");
  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN || state_q == ST_INS) |-> idx_q <= LAST)
    else $error("ring position out of range");
  a_ins_from_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN && state_d == ST_INS |-> !hit_q && !match)
    else $error("insert pass after a hit");
`endif
endmodule

// ----- rtl/nht_cell.sv -----
module nht_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            shift_i,
  input  nht_pkg::entry_t entry_i,
  output nht_pkg::entry_t entry_o
);
  import nht_pkg::*;

  entry_t entry_q;

  // take the neighbor's entry on each shift, empty after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else if (shift_i) begin
      entry_q <= entry_i;
    end
  end

  assign entry_o = entry_q;
endmodule

// ----- rtl/nht_div.sv -----
module nht_div #(
  parameter int DW = 5
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [15:0]   dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] rem_o
);
  logic [15:0]   num_q;
  logic [DW-1:0] div_q;
  logic [DW-1:0] rem_q;
  logic [4:0]    cnt_q;
  logic          busy_q;
  logic [DW:0]   trial;

  // restoring remainder, one dividend bit per cycle
  assign trial = {rem_q, num_q[15]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd15) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[14:0], 1'b0};
      if (trial >= {1'b0, div_q}) rem_q <= DW'(trial - {1'b0, div_q});
      else rem_q <= trial[DW-1:0];
    end
  end

  assign rem_o = rem_q;
endmodule
